// ===== rtl/fba_pkg.sv =====
package fba_pkg;

   // Default table geometry.
   localparam int NUM_BLOCKS_DEF = 32;
   localparam int SIZE_BITS_DEF  = 16;

   // Field widths of the stream items.
   localparam int INDEX_BITS  = 5;
   localparam int REQ_SIZE_BITS = 16;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 6;
   localparam int TDATA_BITS  = 24;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FIT_MODE    = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BLOCK_COUNT = 1'b1;

   // Fit modes.
   localparam logic [1:0] MODE_FIRST = 2'd0;
   localparam logic [1:0] MODE_BEST  = 2'd1;
   localparam logic [1:0] MODE_WORST = 2'd2;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] STATUS_LOADED    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ALLOCATED = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NONE      = 2'd2;

   // Request kinds.
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_REQUEST = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_UPDATE,
      ST_RESULT
   } fba_state_type;

endpackage

// ===== rtl/fit_block_allocator_top.sv =====
// Channel   Direction  Handshake               Contents
// req_      in         req_tvalid/req_tready   tuser: cmd; tdata: block_index, size
// rsp_      out        rsp_tvalid/rsp_tready   tuser: status; tdata: chosen_block, remaining
// csr_      in         csr_we                  csr_index selects fit_mode or block_count
//
// A load writes the table and then presents its result. A request over n active blocks
// (block_count capped at NUM_BLOCKS and 32) makes n table reads into the compare logic,
// drains the read pipeline, writes the chosen block back and then presents its result
// before the sequencer returns to idle.
// A miss skips the write-back; first fit ends the scan once its hit is recorded.
// req_tready is high only when idle; a stalled result in the output register holds the
// sequencer in its result state. Reset is synchronous and active high; the table is not cleared.
module fit_block_allocator_top #(
   parameter int NUM_BLOCKS = fba_pkg::NUM_BLOCKS_DEF,
   parameter int SIZE_BITS  = fba_pkg::SIZE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,  // [0] cmd
   input  logic [fba_pkg::TDATA_BITS-1:0]      req_tdata,  // [4:0] block_index, [20:5] size
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [fba_pkg::STATUS_BITS-1:0]     rsp_tuser,  // [1:0] status
   output logic [fba_pkg::TDATA_BITS-1:0]      rsp_tdata,  // [4:0] chosen_block, [20:5] remaining
   input  logic                                csr_we,
   input  logic [fba_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [fba_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import fba_pkg::*;

   localparam int IDX_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CMP_W   = (SIZE_BITS > REQ_SIZE_BITS) ? SIZE_BITS : REQ_SIZE_BITS;
   localparam int ACT_MAX = (NUM_BLOCKS < 32) ? NUM_BLOCKS : 32;

   // Size table.
   logic [SIZE_BITS-1:0] free_size_mem [NUM_BLOCKS];

   fba_state_type state_ff, state_in;

   logic [1:0]               fit_mode_ff, fit_mode_in;
   logic [COUNT_BITS-1:0]    block_count_ff, block_count_in;
   logic [INDEX_BITS-1:0]    idx_ff, idx_in;
   logic [REQ_SIZE_BITS-1:0] size_ff, size_in;
   logic [COUNT_BITS-1:0]    act_cnt_ff, act_cnt_in;
   logic [COUNT_BITS-1:0]    issue_cnt_ff, issue_cnt_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic [INDEX_BITS-1:0]    rd_idx_ff, rd_idx_in;
   logic [SIZE_BITS-1:0]     rd_data_ff;
   logic                     found_ff, found_in;
   logic [INDEX_BITS-1:0]    pick_ff, pick_in;
   logic [SIZE_BITS-1:0]     best_ff, best_in;
   logic [STATUS_BITS-1:0]   res_status_ff, res_status_in;
   logic [INDEX_BITS-1:0]    res_block_ff, res_block_in;
   logic [REQ_SIZE_BITS-1:0] res_remain_ff, res_remain_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]   rsp_status_ff, rsp_status_in;
   logic [INDEX_BITS-1:0]    rsp_block_ff, rsp_block_in;
   logic [REQ_SIZE_BITS-1:0] rsp_remain_ff, rsp_remain_in;

   logic                     req_accept;
   logic                     out_free;
   logic                     scan_done;
   logic                     load_in_range;
   logic [COUNT_BITS-1:0]    act_limit;
   logic                     fits;
   logic [CMP_W-1:0]         diff;
   logic [SIZE_BITS-1:0]     new_size;
   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   logic [SIZE_BITS-1:0]     mem_wdata;
   logic [IDX_W-1:0]         mem_raddr;

   assign req_accept    = req_tvalid && req_tready;
   assign out_free      = !rsp_valid_ff || rsp_tready;
   assign load_in_range = 32'(idx_ff) < NUM_BLOCKS;
   assign act_limit     = (block_count_ff > COUNT_BITS'(ACT_MAX)) ?
                          COUNT_BITS'(ACT_MAX) : block_count_ff;
   assign fits          = CMP_W'(rd_data_ff) >= CMP_W'(size_ff);
   assign diff          = CMP_W'(best_ff) - CMP_W'(size_ff);
   assign new_size      = diff[SIZE_BITS-1:0];
   assign scan_done     = (fit_mode_ff == MODE_FIRST && found_ff) ||
                          (issue_cnt_ff == act_cnt_ff && !rd_valid_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_tuser == CMD_LOAD) ? ST_LOAD : ST_SCAN;
            end
         end
         ST_LOAD: begin
            state_in = ST_RESULT;
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = found_ff ? ST_UPDATE : ST_RESULT;
            end
         end
         ST_UPDATE: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs and datapath.
   always_comb begin
      req_tready    = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = IDX_W'(idx_ff);
      mem_wdata     = SIZE_BITS'(size_ff);
      mem_raddr     = IDX_W'(issue_cnt_ff);
      idx_in        = idx_ff;
      size_in       = size_ff;
      act_cnt_in    = act_cnt_ff;
      issue_cnt_in  = issue_cnt_ff;
      rd_valid_in   = 1'b0;
      rd_idx_in     = issue_cnt_ff[INDEX_BITS-1:0];
      found_in      = found_ff;
      pick_in       = pick_ff;
      best_in       = best_ff;
      res_status_in = res_status_ff;
      res_block_in  = res_block_ff;
      res_remain_in = res_remain_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_block_in  = rsp_block_ff;
      rsp_remain_in = rsp_remain_ff;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_accept) begin
               idx_in       = req_tdata[INDEX_BITS-1:0];
               size_in      = req_tdata[INDEX_BITS +: REQ_SIZE_BITS];
               act_cnt_in   = act_limit;
               issue_cnt_in = '0;
               found_in     = 1'b0;
            end
         end
         ST_LOAD: begin
            // Store the size truncated to the table width.
            mem_we        = load_in_range;
            res_status_in = STATUS_LOADED;
            res_block_in  = '0;
            res_remain_in = load_in_range ? REQ_SIZE_BITS'(mem_wdata) : '0;
         end
         ST_SCAN: begin
            // Issue one table read per cycle; compare the entry read last cycle.
            if (issue_cnt_ff != act_cnt_ff) begin
               rd_valid_in  = 1'b1;
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
            if (rd_valid_ff && fits) begin
               if (!found_ff) begin
                  if (fit_mode_ff == MODE_FIRST || fit_mode_ff == MODE_BEST ||
                      fit_mode_ff == MODE_WORST) begin
                     found_in = 1'b1;
                     pick_in  = rd_idx_ff;
                     best_in  = rd_data_ff;
                  end
               end else if ((fit_mode_ff == MODE_BEST && rd_data_ff < best_ff) ||
                            (fit_mode_ff == MODE_WORST && rd_data_ff > best_ff)) begin
                  pick_in = rd_idx_ff;
                  best_in = rd_data_ff;
               end
            end
            if (scan_done && !found_ff) begin
               res_status_in = STATUS_NONE;
               res_block_in  = '0;
               res_remain_in = '0;
            end
         end
         ST_UPDATE: begin
            // Write the reduced size back to the chosen block.
            mem_we        = 1'b1;
            mem_waddr     = IDX_W'(pick_ff);
            mem_wdata     = new_size;
            res_status_in = STATUS_ALLOCATED;
            res_block_in  = pick_ff;
            res_remain_in = REQ_SIZE_BITS'(new_size);
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_block_in  = res_block_ff;
               rsp_remain_in = res_remain_ff;
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Configuration registers.
   always_comb begin
      fit_mode_in    = fit_mode_ff;
      block_count_in = block_count_ff;
      if (csr_we) begin
         case (csr_index)
            REG_FIT_MODE:    fit_mode_in    = csr_wdata[1:0];
            REG_BLOCK_COUNT: block_count_in = csr_wdata[COUNT_BITS-1:0];
            default:         fit_mode_in    = fit_mode_ff;
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fit_mode_ff    <= MODE_FIRST;
         block_count_ff <= COUNT_BITS'(32);
         rd_valid_ff    <= 1'b0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fit_mode_ff    <= fit_mode_in;
         block_count_ff <= block_count_in;
         rd_valid_ff    <= rd_valid_in;
         found_ff       <= found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      size_ff       <= size_in;
      act_cnt_ff    <= act_cnt_in;
      issue_cnt_ff  <= issue_cnt_in;
      rd_idx_ff     <= rd_idx_in;
      pick_ff       <= pick_in;
      best_ff       <= best_in;
      res_status_ff <= res_status_in;
      res_block_ff  <= res_block_in;
      res_remain_ff <= res_remain_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_remain_ff <= rsp_remain_in;
   end

   // Table write port and registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         free_size_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= free_size_mem[mem_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(TDATA_BITS - INDEX_BITS - REQ_SIZE_BITS)'(0),
                        rsp_remain_ff, rsp_block_ff};

`ifndef SYNTHESIS
   // A load transaction goes straight to the table write.
   a_load_path: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_LOAD |=> state_ff == ST_LOAD)
      else $error("load transaction did not reach the table write");

   // The write-back only happens for a block that fits.
   a_update_found: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |-> found_ff)
      else $error("write-back without a fitting block");

   // The scan never reads past the active blocks.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> issue_cnt_ff <= act_cnt_ff)
      else $error("scan ran past the active blocks");

   // A new result is loaded only from the result state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(rsp_tvalid && !rsp_tready) |-> $past(state_ff) == ST_RESULT)
      else $error("result appeared outside the result state");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
   import fba_pkg::*;

   localparam int CYCLE_LIMIT  = 800000;
   localparam int RAND_ITEMS   = 1750;
   localparam int HOLD_CYCLES  = 200;
   localparam int SETTLE_WAIT  = 48;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // One allocator result as it appears on the response channel.
   typedef struct packed {
      logic [STATUS_BITS-1:0]   status;
      logic [INDEX_BITS-1:0]    blk;
      logic [REQ_SIZE_BITS-1:0] rem;
   } alloc_result_type;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   // One row of the directed stimulus.
   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_INDEX_BITS-1:0]  csr_sel;
      logic [CSR_DATA_BITS-1:0]   csr_val;
      logic                       cmd;
      logic [INDEX_BITS-1:0]      idx;
      logic [REQ_SIZE_BITS-1:0]   size;
      logic                       typed;
      alloc_result_type           want;
   } stim_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic                        req_tuser = 1'b0;
   logic [TDATA_BITS-1:0]       req_tdata = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [STATUS_BITS-1:0]      rsp_tuser;
   logic [TDATA_BITS-1:0]       rsp_tdata;
   logic                        csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [CSR_DATA_BITS-1:0]    csr_wdata = '0;

   // Shadow copy of the allocator state and configuration.
   logic [REQ_SIZE_BITS-1:0]    free_sizes [32];
   logic [31:0]                 loaded_mask = '0;
   logic [1:0]                  fit_mode_q = MODE_FIRST;
   logic [COUNT_BITS-1:0]       block_count_q = 6'd32;

   alloc_result_type            pending_results [$];
   stim_row_type                directed_rows [$];

   int  cycle_cnt = 0;
   int  err_cnt = 0;
   int  burst_left = 1;
   bit  valid_up = 1'b0;
   bit  hold_req = 1'b0;
   int  hold_cnt = 0;
   int  holds_done = 0;
   int  pauses_done = 0;
   int  items_sent = 0;
   int  rsp_loads = 0;
   int  rsp_allocs = 0;
   int  rsp_refusals = 0;
   int  phases_run = 0;
   alloc_result_type got_res;
   alloc_result_type want_res;

   fit_block_allocator_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
   end

   // Watchdog: a run that overstays the limit is a failure.
   initial begin
      while (cycle_cnt < CYCLE_LIMIT) @(posedge clock);
      $display("[fit_block_allocator_top] ERROR");
      $finish;
   end

   // Number of blocks a request scans, saturated at the table size.
   function automatic int active_blocks();
      return (block_count_q > 6'd32) ? 32 : int'(block_count_q);
   endfunction

   // Applies one transaction to the shadow table and returns its result.
   function automatic alloc_result_type predict_alloc(logic cmd, logic [INDEX_BITS-1:0] idx,
                                                     logic [REQ_SIZE_BITS-1:0] size);
      alloc_result_type res;
      int               n;
      int               pick;
      bit               hit;
      res  = '0;
      pick = 0;
      hit  = 1'b0;
      if (cmd == CMD_LOAD) begin
         free_sizes[idx] = size;
         loaded_mask[idx] = 1'b1;
         res.status = STATUS_LOADED;
         res.rem    = size;
         return res;
      end
      n = active_blocks();
      if (fit_mode_q != MODE_UNUSED) begin
         for (int j = 0; j < n; j++) begin
            if (free_sizes[j] >= size) begin
               if (!hit) begin
                  hit  = 1'b1;
                  pick = j;
                  if (fit_mode_q == MODE_FIRST) break;
               end else if (fit_mode_q == MODE_BEST && free_sizes[j] < free_sizes[pick]) begin
                  pick = j;
               end else if (fit_mode_q == MODE_WORST && free_sizes[j] > free_sizes[pick]) begin
                  pick = j;
               end
            end
         end
      end
      if (hit) begin
         free_sizes[pick] = free_sizes[pick] - size;
         res.status = STATUS_ALLOCATED;
         res.blk    = pick[INDEX_BITS-1:0];
         res.rem    = free_sizes[pick];
      end else begin
         res.status = STATUS_NONE;
      end
      return res;
   endfunction

   // Offers one transaction, records its expected result on acceptance, then paces the
   // sender in bursts separated by random gaps.
   task automatic send_item(logic cmd, logic [INDEX_BITS-1:0] idx,
                            logic [REQ_SIZE_BITS-1:0] size, logic typed,
                            alloc_result_type want);
      alloc_result_type pred;
      int               gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, size, idx};
      valid_up   = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = predict_alloc(cmd, idx, size);
      pending_results.push_back(typed ? want : pred);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            valid_up = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stops offering and waits until every outstanding result has been taken.
   task automatic drain_results();
      if (valid_up) begin
         req_tvalid <= 1'b0;
         valid_up = 1'b0;
      end
      wait (pending_results.size() == 0);
      @(posedge clock);
   endtask

   // Register write; only issued while the allocator is idle.
   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] sel, logic [CSR_DATA_BITS-1:0] val);
      drain_results();
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (sel == REG_FIT_MODE) fit_mode_q = val[1:0];
      else block_count_q = val;
   endtask

   task automatic row_csr(logic [CSR_INDEX_BITS-1:0] sel, logic [CSR_DATA_BITS-1:0] val);
      stim_row_type r;
      r = '0;
      r.kind    = ROW_CSR;
      r.csr_sel = sel;
      r.csr_val = val;
      directed_rows.push_back(r);
   endtask

   task automatic row_item(logic cmd, logic [INDEX_BITS-1:0] idx, logic [REQ_SIZE_BITS-1:0] size,
                           logic typed, logic [STATUS_BITS-1:0] st,
                           logic [INDEX_BITS-1:0] blk, logic [REQ_SIZE_BITS-1:0] rem);
      stim_row_type r;
      r = '0;
      r.kind  = ROW_ITEM;
      r.cmd   = cmd;
      r.idx   = idx;
      r.size  = size;
      r.typed = typed;
      r.want  = '{status: st, blk: blk, rem: rem};
      directed_rows.push_back(r);
   endtask

   // Builds one random transaction. Active blocks that were never loaded are loaded first,
   // so that no request scans an undefined entry.
   task automatic send_random();
      int                       act;
      int                       k;
      int                       unloaded;
      logic [INDEX_BITS-1:0]    idx;
      logic [REQ_SIZE_BITS-1:0] size;
      act = active_blocks();
      unloaded = -1;
      for (int j = act - 1; j >= 0; j--) begin
         if (!loaded_mask[j]) unloaded = j;
      end
      k = (act > 0) ? $urandom_range(0, act - 1) : 0;
      case ($urandom_range(0, 9))
         0: size = '0;
         1: size = '1;
         2, 3, 4, 5: size = REQ_SIZE_BITS'($urandom_range(0, 4000));
         default: size = REQ_SIZE_BITS'($urandom);
      endcase
      if (unloaded >= 0) begin
         send_item(CMD_LOAD, unloaded[INDEX_BITS-1:0], size, 1'b0, '0);
      end else if ($urandom_range(0, 99) < 40) begin
         if (act > 0 && $urandom_range(0, 3) != 0) begin
            idx = INDEX_BITS'($urandom_range(0, act - 1));
         end else begin
            idx = INDEX_BITS'($urandom_range(0, 31));
         end
         send_item(CMD_LOAD, idx, size, 1'b0, '0);
      end else begin
         // Request sizes cluster around the sizes held, to hit exact fits and near misses.
         case ($urandom_range(0, 9))
            0: size = '0;
            1: size = '1;
            2, 3: size = free_sizes[k];
            4: size = free_sizes[k] + 1'b1;
            5: size = free_sizes[k] - 1'b1;
            6, 7: size = REQ_SIZE_BITS'($urandom_range(0, 2000));
            default: size = REQ_SIZE_BITS'($urandom);
         endcase
         idx = INDEX_BITS'($urandom);
         send_item(CMD_REQUEST, idx, size, 1'b0, '0);
      end
   endtask

   // Response side: a changing stall pattern, plus one long hold-off on request.
   initial begin
      int stall_mode;
      int mode_left;
      stall_mode = 0;
      mode_left  = 0;
      forever begin
         @(posedge clock);
         if (mode_left <= 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
         end
         mode_left--;
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES;
            holds_done++;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (mode_left % 16) < 12;
            endcase
         end
      end
   end

   // Result checker: every accepted result is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_res = '{status: rsp_tuser,
                     blk: rsp_tdata[INDEX_BITS-1:0],
                     rem: rsp_tdata[INDEX_BITS +: REQ_SIZE_BITS]};
         case (got_res.status)
            STATUS_LOADED:    rsp_loads++;
            STATUS_ALLOCATED: rsp_allocs++;
            default:          rsp_refusals++;
         endcase
         if (pending_results.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10) begin
               $display("unexpected result: status %0d block %0d remaining %0d",
                        got_res.status, got_res.blk, got_res.rem);
            end
         end else begin
            want_res = pending_results.pop_front();
            if (got_res.status !== want_res.status || got_res.blk !== want_res.blk ||
                got_res.rem !== want_res.rem) begin
               err_cnt++;
               if (err_cnt <= 10) begin
                  $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                           want_res.status, want_res.blk, want_res.rem,
                           got_res.status, got_res.blk, got_res.rem);
               end
            end
         end
      end
   end

   initial begin
      int                    rand_done;
      int                    phase_items;
      int                    p;
      logic [1:0]            mode;
      logic [COUNT_BITS-1:0] count;

      // Directed part: extremes, each fit mode, ties, zero requests and the unused mode.
      row_csr(REG_BLOCK_COUNT, 6'd4);
      row_item(CMD_LOAD, 5'd0, 16'hFFFF, 1'b1, STATUS_LOADED, 5'd0, 16'hFFFF);
      row_item(CMD_LOAD, 5'd1, 16'h0000, 1'b1, STATUS_LOADED, 5'd0, 16'h0000);
      row_item(CMD_LOAD, 5'd2, 16'd100, 1'b1, STATUS_LOADED, 5'd0, 16'd100);
      row_item(CMD_LOAD, 5'd3, 16'd300, 1'b1, STATUS_LOADED, 5'd0, 16'd300);
      row_item(CMD_LOAD, 5'd31, 16'h5A5A, 1'b1, STATUS_LOADED, 5'd0, 16'h5A5A);
      // A zero request fits the first block and leaves it unchanged.
      row_item(CMD_REQUEST, 5'd31, 16'h0000, 1'b1, STATUS_ALLOCATED, 5'd0, 16'hFFFF);
      row_item(CMD_REQUEST, 5'd0, 16'hFFFF, 1'b1, STATUS_ALLOCATED, 5'd0, 16'h0000);
      row_item(CMD_REQUEST, 5'd0, 16'hFFFF, 1'b1, STATUS_NONE, 5'd0, 16'h0000);
      row_item(CMD_REQUEST, 5'd0, 16'd50, 1'b0, STATUS_NONE, 5'd0, 16'h0000);
      row_csr(REG_FIT_MODE, {4'b0000, MODE_BEST});
      row_item(CMD_REQUEST, 5'd0, 16'd40, 1'b0, STATUS_NONE, 5'd0, 16'h0000);
      // Two blocks of equal size: the lower index wins.
      row_item(CMD_LOAD, 5'd1, 16'd10, 1'b1, STATUS_LOADED, 5'd0, 16'd10);
      row_item(CMD_REQUEST, 5'd0, 16'd5, 1'b0, STATUS_NONE, 5'd0, 16'h0000);
      row_item(CMD_REQUEST, 5'd0, 16'd0, 1'b0, STATUS_NONE, 5'd0, 16'h0000);
      row_csr(REG_FIT_MODE, {4'b0000, MODE_WORST});
      row_item(CMD_REQUEST, 5'd0, 16'd100, 1'b0, STATUS_NONE, 5'd0, 16'h0000);
      row_item(CMD_REQUEST, 5'd0, 16'h8000, 1'b1, STATUS_NONE, 5'd0, 16'h0000);
      row_csr(REG_FIT_MODE, {4'b0000, MODE_UNUSED});
      row_item(CMD_REQUEST, 5'd0, 16'd0, 1'b1, STATUS_NONE, 5'd0, 16'h0000);
      // No active block at all.
      row_csr(REG_BLOCK_COUNT, 6'd0);
      row_csr(REG_FIT_MODE, {4'b0000, MODE_FIRST});
      row_item(CMD_REQUEST, 5'd0, 16'd0, 1'b1, STATUS_NONE, 5'd0, 16'h0000);
      row_csr(REG_BLOCK_COUNT, 6'd1);
      row_item(CMD_REQUEST, 5'd0, 16'd0, 1'b1, STATUS_ALLOCATED, 5'd0, 16'h0000);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            csr_write(directed_rows[i].csr_sel, directed_rows[i].csr_val);
         end else begin
            send_item(directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].size,
                      directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // Random part in phases, each with its own fit mode and block count.
      rand_done = 0;
      p = 0;
      while (rand_done < RAND_ITEMS) begin
         mode = (p % 5 == 4) ? MODE_UNUSED : 2'(p % 3);
         case (p)
            0: count = 6'd63;
            1: count = 6'd1;
            2: count = 6'd32;
            3: count = 6'd0;
            4: count = 6'd2;
            default: count = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(32, 63))
                                                           : 6'($urandom_range(1, 31));
         endcase
         csr_write(REG_FIT_MODE, {4'b0000, mode});
         csr_write(REG_BLOCK_COUNT, count);
         phases_run++;
         phase_items = $urandom_range(80, 160);
         for (int i = 0; i < phase_items; i++) begin
            // Long hold-off on the response side while transactions keep coming.
            if (p == 2 && i == 30) hold_req = 1'b1;
            // Sender waits for every outstanding result before going on.
            if (p == 2 && i == 60) begin
               drain_results();
               pauses_done++;
            end
            send_random();
            rand_done++;
         end
         p++;
      end

      drain_results();
      repeat (SETTLE_WAIT) @(posedge clock);

      $display("Ran %0d transactions: %0d loads, %0d allocations, %0d refusals.",
               items_sent, rsp_loads, rsp_allocs, rsp_refusals);
      $display("Covered %0d random phases across all fit modes and block counts 0 to 63, %0d %s",
               phases_run, holds_done, "long response hold-off(s).");
      if (err_cnt == 0 && pending_results.size() == 0) begin
         $display("[fit_block_allocator_top] OK");
      end else begin
         $display("[fit_block_allocator_top] ERROR");
      end
      $finish;
   end

endmodule
